[src/mks_pkg.sv]
// Package: shared constants, types and the fractional power factor table.
package mks_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DVD_W     = 48;
   localparam int POW_W     = 33;
   localparam int R_W       = 24;
   localparam logic [R_W-1:0] R_MAX = {R_W{1'b1}};
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef logic [FRAC_BITS:1][31:0] factor_tab_type;

   // Floor square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] rem;
      res   = '0;
      rem   = v;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bit_v != 0) begin
            if (rem >= res + bit_v) begin
               rem = rem - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // Factors 2^-(2^-j) in Q0.32 by repeated square roots
   function automatic factor_tab_type calc_factors();
      factor_tab_type tab;
      logic [63:0] t;
      t = isqrt64(64'h8000_0000_0000_0000);
      tab[1] = t[31:0];
      for (int j = 2; j <= FRAC_BITS; j++) begin
         t = isqrt64({tab[j-1], 32'h0});
         tab[j] = t[31:0];
      end
      return tab;
   endfunction

   localparam factor_tab_type FACTORS = calc_factors();

endpackage

[src/median_and_exponential_ks_test.sv]
// Median and exponential Kolmogorov-Smirnov distance of a sample set.
//
// Input channel req_: one sample per transaction in req_tdata, req_tlast marks
// the final sample of a set. Each stored sample is inserted in sorted order
// into a single-port-read, single-port-write memory: the insertion walks down
// from the top, reading and then comparing each entry, while a sample into an
// empty set is written directly. Samples beyond MAX_SAMPLES are dropped and
// flagged. After the last sample the median is read and checked; then each
// sorted sample goes through a read and divider load, a shift-subtract
// divider, the 16-step power product and the deviation update, and a final
// divide by n gives the statistic. One result transaction on rsp_ follows each
// set. The result sits in an output register: the next set may load while it
// waits, and only a second finished result waits for it.
// Reset empties the set, clears the overflow flag and drops any pending result.
module median_and_exponential_ks_test #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [31:0] median, [48:32] ks_stat,
                                    // [49] stat_valid, [50] overflowed
);

   localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int BW = CW + 18;
   localparam int SB = SAMPLE_BITS;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);
   localparam int DVD_W_L = mks_pkg::DVD_W;

   typedef enum logic [4:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT0, S_MED_A, S_MED_B, S_MED_C,
      S_CHK, S_RD, S_DIVLD, S_DIV, S_POW, S_EVAL, S_CMP, S_FDIV, S_OUT
   } state_type;

   state_type state_ff;
   logic [SB-1:0] mem [MAX_SAMPLES];
   logic [SB-1:0] rd_data_ff;
   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic          last_ff;
   logic [SB-1:0] new_ff;
   logic [AW-1:0] pos_ff;
   logic [SB-1:0] hi_ff;
   logic [31:0]   med_ff;
   logic [CW-1:0] n_ff;
   logic [AW-1:0] idx_ff;
   logic [BW-1:0] best_ff;
   logic [33:0]   nf_ff;
   logic          fin_ff;
   logic [DVD_W_L-1:0] dvd_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   dvs_ff;
   logic [5:0]    dcnt_ff;
   logic [mks_pkg::R_W-1:0] r_ff;
   logic [mks_pkg::POW_W-1:0] acc_ff;
   logic [4:0]    pj_ff;
   logic          rsp_valid_ff;
   logic [55:0]   rsp_data_ff;
   logic [16:0]   ks_ff;
   logic          sv_ff;

   // Memory ports
   logic          we;
   logic [AW-1:0] wa;
   logic [SB-1:0] wd;
   logic [AW-1:0] ra;
   logic          req_acc;
   logic [SB-1:0] req_s;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign req_s      = req_tdata[SB-1:0];

   always_comb begin
      we = 1'b0;
      wa = pos_ff + AW'(1);
      wd = new_ff;
      ra = pos_ff;
      case (state_ff)
         S_IDLE: begin
            we = req_acc && (count_ff == '0);
            wa = '0;
            wd = req_s;
         end
         S_INS_CMP: begin
            we = 1'b1;
            wd = (rd_data_ff > new_ff) ? rd_data_ff : new_ff;
         end
         S_INS_PUT0: begin
            we = 1'b1;
            wa = '0;
         end
         S_MED_A: ra = AW'(n_ff >> 1);
         S_MED_B: ra = AW'((n_ff >> 1) - CW'(1));
         S_RD:    ra = idx_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

   // Divider step: one quotient bit a cycle
   logic [32:0] rem_sh_in;
   logic        qbit_in;
   logic [32:0] rem_sub_in;
   assign rem_sh_in  = {rem_ff, dvd_ff[DVD_W_L-1]};
   assign qbit_in    = (rem_sh_in >= {1'b0, dvs_ff});
   assign rem_sub_in = rem_sh_in - {1'b0, dvs_ff};

   // Power step: multiply by one table factor
   logic [3:0]  fidx_in;
   logic [64:0] prod_in;
   assign fidx_in = 4'(5'd16 - pj_ff);
   assign prod_in = acc_ff * mks_pkg::FACTORS[pj_ff];

   // CDF from accumulated power and integer part
   logic [7:0]  k_in;
   logic [mks_pkg::POW_W-1:0] p_sh_in;
   logic [16:0] p_in;
   logic [16:0] f_in;
   always_comb begin
      k_in    = r_ff[23:16];
      p_sh_in = acc_ff >> (6'd16 + k_in[5:0]);
      if (k_in >= 8'd17) begin
         p_in = '0;
      end else if (p_sh_in > 33'(mks_pkg::ONE_Q16)) begin
         p_in = mks_pkg::ONE_Q16;
      end else begin
         p_in = p_sh_in[16:0];
      end
      f_in = mks_pkg::ONE_Q16 - p_in;
   end

   // Deviation candidates
   logic [BW-1:0] up_in;
   logic [BW-1:0] lo_in;
   logic [BW-1:0] nfw_in;
   assign up_in  = BW'({{(BW-AW){1'b0}}, idx_ff} + BW'(1)) << 16;
   assign lo_in  = BW'(idx_ff) << 16;
   assign nfw_in = BW'(nf_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one loads now
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  last_ff <= req_tlast;
                  new_ff  <= req_s;
                  pos_ff  <= AW'(count_ff - CW'(1));
                  if (count_ff == MAX_CNT) begin
                     ovf_ff <= 1'b1;
                     if (req_tlast) state_ff <= S_MED_A;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                     if (count_ff != '0) begin
                        state_ff <= S_INS_RD;
                     end else if (req_tlast) begin
                        state_ff <= S_MED_A;
                     end
                  end
                  n_ff <= (count_ff == MAX_CNT) ? count_ff : count_ff + CW'(1);
               end
            end
            S_INS_RD: state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               if (rd_data_ff > new_ff) begin
                  if (pos_ff == '0) begin
                     state_ff <= S_INS_PUT0;
                  end else begin
                     pos_ff   <= pos_ff - AW'(1);
                     state_ff <= S_INS_RD;
                  end
               end else begin
                  state_ff <= last_ff ? S_MED_A : S_IDLE;
               end
            end
            S_INS_PUT0: state_ff <= last_ff ? S_MED_A : S_IDLE;
            S_MED_A: state_ff <= S_MED_B;
            S_MED_B: begin
               hi_ff <= rd_data_ff;
               if (n_ff[0]) begin
                  med_ff   <= 32'(rd_data_ff);
                  state_ff <= S_CHK;
               end else begin
                  state_ff <= S_MED_C;
               end
            end
            S_MED_C: begin
               med_ff   <= 32'(({1'b0, rd_data_ff} + {1'b0, hi_ff}) >> 1);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               idx_ff  <= '0;
               best_ff <= '0;
               if (med_ff == '0) begin
                  ks_ff    <= '0;
                  sv_ff    <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  sv_ff    <= 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_DIVLD;
            S_DIVLD: begin
               dvd_ff   <= DVD_W_L'(rd_data_ff) << mks_pkg::FRAC_BITS;
               dvs_ff   <= med_ff;
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               fin_ff   <= 1'b0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= qbit_in ? rem_sub_in[31:0] : rem_sh_in[31:0];
               dvd_ff  <= {dvd_ff[DVD_W_L-2:0], qbit_in};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'(DVD_W_L - 1)) begin
                  if (fin_ff) begin
                     if ({dvd_ff[DVD_W_L-2:0], qbit_in} > DVD_W_L'(mks_pkg::ONE_Q16)) begin
                        ks_ff <= mks_pkg::ONE_Q16;
                     end else begin
                        ks_ff <= dvd_ff[15:0] == '0 && !qbit_in ? 17'(0) :
                                 17'({dvd_ff[15:0], qbit_in});
                     end
                     state_ff <= S_OUT;
                  end else begin
                     if ({dvd_ff[DVD_W_L-2:0], qbit_in} > DVD_W_L'(mks_pkg::R_MAX)) begin
                        r_ff <= mks_pkg::R_MAX;
                     end else begin
                        r_ff <= {dvd_ff[22:0], qbit_in};
                     end
                     acc_ff   <= mks_pkg::POW_W'(64'h1_0000_0000);
                     pj_ff    <= 5'd1;
                     state_ff <= S_POW;
                  end
               end
            end
            S_POW: begin
               if (r_ff[fidx_in]) begin
                  acc_ff <= prod_in[64:32];
               end
               pj_ff <= pj_ff + 5'd1;
               if (pj_ff == 5'(mks_pkg::FRAC_BITS)) state_ff <= S_EVAL;
            end
            S_EVAL: begin
               nf_ff    <= 34'(n_ff) * 34'(f_in);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (up_in > nfw_in && up_in - nfw_in > best_ff &&
                   !(nfw_in > lo_in && nfw_in - lo_in > up_in - nfw_in)) begin
                  best_ff <= up_in - nfw_in;
               end else if (nfw_in > lo_in && nfw_in - lo_in > best_ff) begin
                  best_ff <= nfw_in - lo_in;
               end
               if (CW'(idx_ff) == n_ff - CW'(1)) begin
                  state_ff <= S_FDIV;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= S_RD;
               end
            end
            S_FDIV: begin
               dvd_ff   <= DVD_W_L'(best_ff);
               dvs_ff   <= 32'(n_ff);
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               fin_ff   <= 1'b1;
               state_ff <= S_DIV;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'd0, ovf_ff, sv_ff, ks_ff, med_ff};
                  count_ff     <= '0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Fill count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("sample count above capacity");

   // Power steps stay within the factor table
   a_pow_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POW) |-> (pj_ff >= 5'd1 && pj_ff <= 5'(mks_pkg::FRAC_BITS)))
      else $error("power step index out of range");

   // Running maximum stays within n full units
   a_best_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FDIV) |-> (best_ff <= (BW'(n_ff) << 16)))
      else $error("deviation above bound");

   // A new result only loads when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> state_ff == S_OUT)
      else $error("result overwritten while stalled");

endmodule
